FILE: rtl/hpi_pkg.sv
// ----------------------------------------------------------------------------
// hpi_pkg
// Shared types, constants and the quarter-wave sine table of the heading and
// position integrator.
// ----------------------------------------------------------------------------
package hpi_pkg;

    // field widths
    localparam int OP_W    = 3;
    localparam int POS_W   = 24;
    localparam int HDG_W   = 15;
    localparam int VEL_W   = 17;
    localparam int SPEED_W = 16;
    localparam int TBL_W   = 15;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    // stream packing
    localparam int S_FIELDS_W = OP_W + 2 * POS_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 2 * POS_W + HDG_W + 2 * VEL_W + 1;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // opcodes
    localparam logic [OP_W-1:0] OP_ROT_R = 3'd0;
    localparam logic [OP_W-1:0] OP_ROT_L = 3'd1;
    localparam logic [OP_W-1:0] OP_FWD   = 3'd2;
    localparam logic [OP_W-1:0] OP_BWD   = 3'd3;
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd4;
    localparam logic [OP_W-1:0] OP_HOLD  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_STEP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_SPEED = 1'b1;
    localparam logic [HDG_W-1:0]     TURN_STEP_RST  = 15'd320;
    localparam logic [SPEED_W-1:0]   MOVE_SPEED_RST = 16'd256;

    // angle arithmetic: 64 units per degree
    localparam int FULL_TURN     = 23040;
    localparam int QUARTER_TURN  = 5760;
    localparam int HALF_QUARTER  = QUARTER_TURN / 2;
    localparam int REM_W         = 13;
    // 5760 = 45 * 2^7
    localparam int QUARTER_SHIFT = 7;
    localparam int QUARTER_ODD   = QUARTER_TURN >> QUARTER_SHIFT;

    // sine table size
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_N = 1 << SINE_TABLE_BITS;
    localparam int IDX_W  = SINE_TABLE_BITS + 1;
    localparam int NUM_W  = SINE_TABLE_BITS + REM_W + 1;
    localparam int M_W    = SINE_TABLE_BITS + 6;

    // reciprocal of 45 for the table index division
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_K     = (1 << RECIP_SHIFT) / QUARTER_ODD;
    localparam int RECIP_W     = 19;

    // pipeline depth between input register and result register
    localparam int NSTG = 6;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] load_x;
        logic [POS_W-1:0] load_y;
        logic [HDG_W-1:0] heading;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [HDG_W-1:0] heading;
        logic [VEL_W-1:0] vel_x;
        logic [VEL_W-1:0] vel_y;
        logic             saturated;
    } result_t;

    typedef logic [TBL_W-1:0] sine_lut_t [0:SINE_N];

    // Q1.15 quarter sine, integer Taylor series in Q30, evaluated at elaboration
    function automatic sine_lut_t build_sine_lut();
        sine_lut_t          lut;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        q;
        for (int k = 0; k <= SINE_N; k++) begin
            x    = (64'd1686629713 * 64'(k)) >> SINE_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - signed'(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + signed'(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - signed'(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + signed'(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - signed'(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + signed'(term);
            term = ((term * x2) >> 30) / 64'd210;
            sum  = sum - signed'(term);
            if (sum < 64'sd0) begin
                sum = 64'sd0;
            end
            if (sum > 64'sd1073741824) begin
                sum = 64'sd1073741824;
            end
            q = (unsigned'(sum) * 64'd32768 + 64'd536870912) >> 30;
            if (q > 64'd32767) begin
                q = 64'd32767;
            end
            lut[k] = q[TBL_W-1:0];
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

FILE: rtl/hpi_heading.sv
// ----------------------------------------------------------------------------
// hpi_heading
// Heading state and its rotate update, wrapping modulo one full turn.
// ----------------------------------------------------------------------------
module hpi_heading import hpi_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [OP_W-1:0]  op,
    input  logic [HDG_W-1:0] turn_step,
    output logic [HDG_W-1:0] heading_next
);

    logic [HDG_W-1:0] heading_reg;
    logic [HDG_W:0]   sum_r;
    logic [HDG_W:0]   sum_l;

    // turn_step is kept below a full turn, heading too
    assign sum_r = {1'b0, heading_reg} + {1'b0, turn_step};
    assign sum_l = {1'b0, heading_reg} + (HDG_W+1)'(FULL_TURN) - {1'b0, turn_step};

    always_comb begin
        unique case (op)
            OP_ROT_R: begin
                if (sum_r >= (HDG_W+1)'(FULL_TURN)) begin
                    heading_next = HDG_W'(sum_r - (HDG_W+1)'(FULL_TURN));
                end else begin
                    heading_next = sum_r[HDG_W-1:0];
                end
            end
            OP_ROT_L: begin
                if (heading_reg >= turn_step) begin
                    heading_next = heading_reg - turn_step;
                end else begin
                    heading_next = sum_l[HDG_W-1:0];
                end
            end
            default: begin
                heading_next = heading_reg;
            end
        endcase
    end

    // heading advances once per accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heading_reg <= '0;
        end else if (accept) begin
            heading_reg <= heading_next;
        end
    end

endmodule

FILE: rtl/hpi_angle_index.sv
// ----------------------------------------------------------------------------
// hpi_angle_index
// Splits a heading into quadrant and sine table index over three stages:
// quadrant and scaled remainder, reciprocal multiply, quotient correction.
// ----------------------------------------------------------------------------
module hpi_angle_index import hpi_pkg::*; (
    input  logic             aclk,
    input  logic [2:0]       stg_en,
    input  logic [HDG_W-1:0] heading,
    output logic [1:0]       quad,
    output logic [IDX_W-1:0] idx
);

    logic [1:0]               quad1_reg;
    logic [M_W-1:0]           m1_reg;
    logic [1:0]               quad2_reg;
    logic [M_W-1:0]           m2_reg;
    logic [IDX_W-1:0]         q2_reg;
    logic [1:0]               quad3_reg;
    logic [IDX_W-1:0]         idx3_reg;

    logic [1:0]               quad_c;
    logic [REM_W-1:0]         rem_c;
    logic [NUM_W-1:0]         num_c;
    logic [M_W+RECIP_W-1:0]   prod_c;
    logic [M_W:0]             q45_c;
    logic [M_W:0]             diff_c;

    // quadrant and remainder within it
    always_comb begin
        priority if (heading < HDG_W'(QUARTER_TURN)) begin
            quad_c = 2'd0;
            rem_c  = REM_W'(heading);
        end else if (heading < HDG_W'(2 * QUARTER_TURN)) begin
            quad_c = 2'd1;
            rem_c  = REM_W'(heading - HDG_W'(QUARTER_TURN));
        end else if (heading < HDG_W'(3 * QUARTER_TURN)) begin
            quad_c = 2'd2;
            rem_c  = REM_W'(heading - HDG_W'(2 * QUARTER_TURN));
        end else begin
            quad_c = 2'd3;
            rem_c  = REM_W'(heading - HDG_W'(3 * QUARTER_TURN));
        end
    end

    // rounded index numerator, with the power-of-two part of 5760 shifted off
    assign num_c = (NUM_W'(rem_c) << SINE_TABLE_BITS) + NUM_W'(HALF_QUARTER);

    always_ff @(posedge aclk) begin
        if (stg_en[0]) begin
            quad1_reg <= quad_c;
            m1_reg    <= M_W'(num_c >> QUARTER_SHIFT);
        end
    end

    // quotient estimate by reciprocal of 45, low by at most one
    assign prod_c = (M_W+RECIP_W)'(m1_reg) * (M_W+RECIP_W)'(RECIP_K);

    always_ff @(posedge aclk) begin
        if (stg_en[1]) begin
            quad2_reg <= quad1_reg;
            m2_reg    <= m1_reg;
            q2_reg    <= IDX_W'(prod_c >> RECIP_SHIFT);
        end
    end

    // one correction step
    assign q45_c  = (M_W+1)'(q2_reg) * (M_W+1)'(QUARTER_ODD);
    assign diff_c = {1'b0, m2_reg} - q45_c;

    always_ff @(posedge aclk) begin
        if (stg_en[2]) begin
            quad3_reg <= quad2_reg;
            if (diff_c >= (M_W+1)'(QUARTER_ODD)) begin
                idx3_reg <= q2_reg + IDX_W'(1);
            end else begin
                idx3_reg <= q2_reg;
            end
        end
    end

    assign quad = quad3_reg;
    assign idx  = idx3_reg;

endmodule

FILE: rtl/hpi_velocity.sv
// ----------------------------------------------------------------------------
// hpi_velocity
// Sine table ROM with two registered read ports, then speed scaling with
// round half away from zero and quadrant signs.
// ----------------------------------------------------------------------------
module hpi_velocity import hpi_pkg::*; (
    input  logic               aclk,
    input  logic [1:0]         stg_en,
    input  logic [1:0]         quad,
    input  logic [IDX_W-1:0]   idx,
    input  logic [SPEED_W-1:0] move_speed,
    output logic [VEL_W-1:0]   vel_x,
    output logic [VEL_W-1:0]   vel_y
);

    logic [TBL_W-1:0]             sin_a_reg;
    logic [TBL_W-1:0]             sin_b_reg;
    logic [1:0]                   quad4_reg;
    logic [VEL_W-1:0]             vel_x_reg;
    logic [VEL_W-1:0]             vel_y_reg;

    logic [SPEED_W+TBL_W:0]       rnd_a;
    logic [SPEED_W+TBL_W:0]       rnd_b;
    logic [VEL_W-1:0]             mag_a;
    logic [VEL_W-1:0]             mag_b;
    logic [VEL_W-1:0]             mag_x;
    logic [VEL_W-1:0]             mag_y;

    // ROM read: sine at idx and at the mirrored index
    always_ff @(posedge aclk) begin
        if (stg_en[0]) begin
            sin_a_reg <= SINE_LUT[idx];
            sin_b_reg <= SINE_LUT[IDX_W'(SINE_N) - idx];
            quad4_reg <= quad;
        end
    end

    // speed * table / 32768, rounded
    assign rnd_a = (SPEED_W+TBL_W+1)'(move_speed) * (SPEED_W+TBL_W+1)'(sin_a_reg)
                 + (SPEED_W+TBL_W+1)'(16384);
    assign rnd_b = (SPEED_W+TBL_W+1)'(move_speed) * (SPEED_W+TBL_W+1)'(sin_b_reg)
                 + (SPEED_W+TBL_W+1)'(16384);
    assign mag_a = VEL_W'(rnd_a >> 15);
    assign mag_b = VEL_W'(rnd_b >> 15);

    // odd quadrants swap sine and cosine
    assign mag_x = quad4_reg[0] ? mag_b : mag_a;
    assign mag_y = quad4_reg[0] ? mag_a : mag_b;

    // vel_x negative in the left half, vel_y negative in the upper half
    always_ff @(posedge aclk) begin
        if (stg_en[1]) begin
            vel_x_reg <= quad4_reg[1] ? (~mag_x + VEL_W'(1)) : mag_x;
            vel_y_reg <= (quad4_reg[1] == quad4_reg[0]) ? (~mag_y + VEL_W'(1)) : mag_y;
        end
    end

    assign vel_x = vel_x_reg;
    assign vel_y = vel_y_reg;

endmodule

FILE: rtl/hpi_position.sv
// ----------------------------------------------------------------------------
// hpi_position
// Position state with saturating move, load, and the result register.
// ----------------------------------------------------------------------------
module hpi_position import hpi_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  item_t            item,
    input  logic [VEL_W-1:0] vel_x,
    input  logic [VEL_W-1:0] vel_y,
    output result_t          result
);

    localparam logic signed [POS_W+1:0] SUM_MAX = (POS_W+2)'((1 << (POS_W-1)) - 1);
    localparam logic signed [POS_W+1:0] SUM_MIN = (POS_W+2)'(-(1 << (POS_W-1)));

    logic signed [POS_W-1:0] x_reg;
    logic signed [POS_W-1:0] y_reg;
    logic [HDG_W-1:0]        heading_reg;
    logic [VEL_W-1:0]        vel_x_reg;
    logic [VEL_W-1:0]        vel_y_reg;
    logic                    sat_reg;

    logic signed [POS_W+1:0] vx_ext;
    logic signed [POS_W+1:0] vy_ext;
    logic signed [POS_W+1:0] sum_x;
    logic signed [POS_W+1:0] sum_y;
    logic signed [POS_W-1:0] x_next;
    logic signed [POS_W-1:0] y_next;
    logic                    clip_x;
    logic                    clip_y;
    logic                    sat_next;

    assign vx_ext = (POS_W+2)'(signed'(vel_x));
    assign vy_ext = (POS_W+2)'(signed'(vel_y));
    assign sum_x  = (item.op == OP_BWD) ? ((POS_W+2)'(x_reg) - vx_ext)
                                        : ((POS_W+2)'(x_reg) + vx_ext);
    assign sum_y  = (item.op == OP_BWD) ? ((POS_W+2)'(y_reg) - vy_ext)
                                        : ((POS_W+2)'(y_reg) + vy_ext);
    assign clip_x = (sum_x > SUM_MAX) || (sum_x < SUM_MIN);
    assign clip_y = (sum_y > SUM_MAX) || (sum_y < SUM_MIN);

    // next position by command
    always_comb begin
        x_next   = x_reg;
        y_next   = y_reg;
        sat_next = 1'b0;
        unique case (item.op)
            OP_FWD, OP_BWD: begin
                if (sum_x > SUM_MAX) begin
                    x_next = POS_W'(SUM_MAX);
                end else if (sum_x < SUM_MIN) begin
                    x_next = POS_W'(SUM_MIN);
                end else begin
                    x_next = POS_W'(sum_x);
                end
                if (sum_y > SUM_MAX) begin
                    y_next = POS_W'(SUM_MAX);
                end else if (sum_y < SUM_MIN) begin
                    y_next = POS_W'(SUM_MIN);
                end else begin
                    y_next = POS_W'(sum_y);
                end
                sat_next = clip_x | clip_y;
            end
            OP_LOAD: begin
                x_next = signed'(item.load_x);
                y_next = signed'(item.load_y);
            end
            default: begin
                x_next = x_reg;
                y_next = y_reg;
            end
        endcase
    end

    // position state doubles as the result position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
            y_reg <= '0;
        end else if (load) begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            heading_reg <= item.heading;
            vel_x_reg   <= vel_x;
            vel_y_reg   <= vel_y;
            sat_reg     <= sat_next;
        end
    end

    assign result.pos_x     = x_reg;
    assign result.pos_y     = y_reg;
    assign result.heading   = heading_reg;
    assign result.vel_x     = vel_x_reg;
    assign result.vel_y     = vel_y_reg;
    assign result.saturated = sat_reg;

endmodule

FILE: rtl/heading_position_integrator_unit.sv
// ----------------------------------------------------------------------------
// heading_position_integrator_unit
// Dead reckoning: heading rotate, move along heading, load and hold, with a
// velocity readout on every result beat.
// ----------------------------------------------------------------------------
//  channel  | dir | ports                                | contents
//  s_       | in  | s_tvalid s_tready s_tdata[55:0]      | one command beat
//  m_       | out | m_tvalid m_tready m_tdata[103:0]     | one result beat
//  cfg_wr_  | in  | cfg_wr_en cfg_wr_index cfg_wr_data   | turn_step, move_speed
//
// One command per cycle sustained while m_tready keeps up. Each beat passes
// seven register stages: heading update, quadrant split, reciprocal
// multiply, index correction, sine ROM read, speed multiply, position
// update. The heading and position updates each close in their own
// register stage, so dependent commands follow back to back.
// Reset (synchronous, active low) empties the pipeline and clears heading
// and position. Stalls on m_tready fill bubbles first, then back up to s_tready.
// ----------------------------------------------------------------------------
module heading_position_integrator_unit import hpi_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    // command stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: opcode[2:0], load_x[26:3], load_y[50:27], zero[55:51]
    input  logic [S_DATA_W-1:0]  s_tdata,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: pos_x[23:0], pos_y[47:24], heading[62:48], vel_x[79:63],
    //          vel_y[96:80], saturated[97], zero[103:98]
    output logic [M_DATA_W-1:0]  m_tdata
);

    logic [HDG_W-1:0]   turn_step_reg;
    logic [SPEED_W-1:0] move_speed_reg;
    logic [HDG_W-1:0]   step_wrap;

    logic [NSTG-1:0]    stg_vld_reg;
    logic [NSTG-1:0]    stg_en;
    logic               m_tvalid_reg;
    logic               out_rdy;
    logic               s_accept;
    logic               out_load;

    item_t              item_pipe_reg [0:NSTG-1];
    item_t              item_in;
    logic [HDG_W-1:0]   heading_next;
    logic [1:0]         quad;
    logic [IDX_W-1:0]   idx;
    logic [VEL_W-1:0]   vel_x;
    logic [VEL_W-1:0]   vel_y;
    result_t            result;

    // configuration; the turn step is stored already reduced below a full turn
    assign step_wrap = (cfg_wr_data[HDG_W-1:0] >= HDG_W'(FULL_TURN))
                     ? (cfg_wr_data[HDG_W-1:0] - HDG_W'(FULL_TURN))
                     : cfg_wr_data[HDG_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            turn_step_reg  <= TURN_STEP_RST;
            move_speed_reg <= MOVE_SPEED_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_TURN_STEP:  turn_step_reg  <= step_wrap;
                CFG_MOVE_SPEED: move_speed_reg <= cfg_wr_data[SPEED_W-1:0];
            endcase
        end
    end

    // pipeline flow: a stage loads when it is empty or its successor moves
    assign out_rdy = !m_tvalid_reg || m_tready;

    always_comb begin
        stg_en[NSTG-1] = !stg_vld_reg[NSTG-1] || out_rdy;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_en[k] = !stg_vld_reg[k] || stg_en[k+1];
        end
    end

    assign s_tready = stg_en[0];
    assign s_accept = s_tvalid && stg_en[0];
    assign out_load = stg_vld_reg[NSTG-1] && out_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_vld_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (stg_en[0]) begin
                stg_vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_en[k]) begin
                    stg_vld_reg[k] <= stg_vld_reg[k-1];
                end
            end
            if (out_rdy) begin
                m_tvalid_reg <= stg_vld_reg[NSTG-1];
            end
        end
    end

    // heading stage
    hpi_heading u_heading (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_accept),
        .op           (s_tdata[OP_W-1:0]),
        .turn_step    (turn_step_reg),
        .heading_next (heading_next)
    );

    assign item_in.op      = s_tdata[OP_W-1:0];
    assign item_in.load_x  = s_tdata[OP_W+POS_W-1:OP_W];
    assign item_in.load_y  = s_tdata[OP_W+2*POS_W-1:OP_W+POS_W];
    assign item_in.heading = heading_next;

    // command sideband rides along with the datapath stages
    always_ff @(posedge aclk) begin
        if (stg_en[0]) begin
            item_pipe_reg[0] <= item_in;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (stg_en[k]) begin
                item_pipe_reg[k] <= item_pipe_reg[k-1];
            end
        end
    end

    hpi_angle_index u_angle_index (
        .aclk    (aclk),
        .stg_en  (stg_en[3:1]),
        .heading (item_pipe_reg[0].heading),
        .quad    (quad),
        .idx     (idx)
    );

    hpi_velocity u_velocity (
        .aclk       (aclk),
        .stg_en     (stg_en[5:4]),
        .quad       (quad),
        .idx        (idx),
        .move_speed (move_speed_reg),
        .vel_x      (vel_x),
        .vel_y      (vel_y)
    );

    hpi_position u_position (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (out_load),
        .item    (item_pipe_reg[NSTG-1]),
        .vel_x   (vel_x),
        .vel_y   (vel_y),
        .result  (result)
    );

    // result beat packing
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_DATA_W - M_FIELDS_W)'(0), result.saturated, result.vel_y,
                       result.vel_x, result.heading, result.pos_y, result.pos_x};

endmodule

FILE: rtl/hpi_checker.sv
// ----------------------------------------------------------------------------
// hpi_checker
// Port-level checks of the heading and position integrator, bound to the
// top level.
// ----------------------------------------------------------------------------
module hpi_checker import hpi_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_DATA_W-1:0]  m_tdata
);

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // reported heading stays within one turn
    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[62:48] < HDG_W'(FULL_TURN))
        else $error("heading out of range");

    // velocity magnitude never reaches 2^16
    a_vel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[79:63] != 17'h10000) && (m_tdata[96:80] != 17'h10000))
        else $error("velocity out of range");

    // a clipped move leaves a coordinate at a range limit
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[97] |->
            (m_tdata[23:0] == 24'h7FFFFF) || (m_tdata[23:0] == 24'h800000) ||
            (m_tdata[47:24] == 24'h7FFFFF) || (m_tdata[47:24] == 24'h800000))
        else $error("saturated flag without a clipped coordinate");

endmodule

bind heading_position_integrator_unit hpi_checker u_hpi_checker (.*);

FILE: test/hpi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpi_scoreboard
// Watches the command, result and register-write ports of the heading and
// position integrator. It keeps its own copy of heading, position and both
// registers, predicts one result per accepted command and compares every
// result beat field by field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module hpi_scoreboard import hpi_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // s_tdata: opcode, load_x, load_y, zero fill
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: pos_x, pos_y, heading, vel_x, vel_y, saturated, zero fill
    input  logic [M_DATA_W-1:0]  m_tdata,
    output int                   error_count,
    output int                   pending_count,
    output int                   beats_checked,
    output int                   clipped_moves
);

    localparam int     LUT_BITS       = 10;
    localparam int     LUT_N          = 1 << LUT_BITS;
    localparam int     TURN_UNITS     = 23040;
    localparam int     QUADRANT_UNITS = 5760;
    localparam longint COORD_MAX      = 64'sd8388607;
    localparam longint COORD_MIN      = -64'sd8388608;

    logic [15:0] quarter_sine [0:LUT_N];

    // model state and register copies
    int      turn_cfg;
    int      speed_cfg;
    int      hdg_st;
    longint  px_st;
    longint  py_st;
    result_t expected_beats [$];

    int n_errors;
    int n_pending;
    int n_checked;
    int n_clipped;

    assign error_count   = n_errors;
    assign pending_count = n_pending;
    assign beats_checked = n_checked;
    assign clipped_moves = n_clipped;

    // quarter-wave sine in Q1.15: Taylor series to x^15 in Q30
    initial begin
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned q;
        longint          sum;
        for (int k = 0; k <= LUT_N; k++) begin
            x    = (64'd1686629713 * 64'(k)) >> LUT_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > 64'sd1073741824) begin
                sum = 64'sd1073741824;
            end
            q = ($unsigned(sum) * 64'd32768 + 64'd536870912) >> 30;
            if (q > 64'd32767) begin
                q = 64'd32767;
            end
            quarter_sine[k] = q[15:0];
        end
    end

    task automatic flag_error(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want) begin
            flag_error($sformatf("beat %0d %s: got 0x%0h, expected 0x%0h",
                                 n_checked, name, got, want));
        end
    endtask

    // speed * table / 2^15, rounded half away from zero
    function automatic longint scaled(input logic [15:0] entry, input bit neg);
        longint m;
        m = (longint'(speed_cfg) * longint'(entry) + 16384) >>> 15;
        return neg ? -m : m;
    endfunction

    // velocity at a heading: x = speed*sin, y = -speed*cos (screen Y down)
    function automatic void heading_velocity(input int h, output longint vx,
                                             output longint vy);
        int          quad;
        int          rem;
        int          idx;
        logic [15:0] a;
        logic [15:0] b;
        longint      s;
        longint      c;
        quad = h / QUADRANT_UNITS;
        rem  = h % QUADRANT_UNITS;
        idx  = (rem * LUT_N + QUADRANT_UNITS / 2) / QUADRANT_UNITS;
        a    = quarter_sine[idx];
        b    = quarter_sine[LUT_N - idx];
        case (quad)
            0: begin
                s = scaled(a, 1'b0);
                c = scaled(b, 1'b0);
            end
            1: begin
                s = scaled(b, 1'b0);
                c = scaled(a, 1'b1);
            end
            2: begin
                s = scaled(a, 1'b1);
                c = scaled(b, 1'b1);
            end
            default: begin
                s = scaled(b, 1'b1);
                c = scaled(a, 1'b0);
            end
        endcase
        vx = s;
        vy = -c;
    endfunction

    function automatic longint clamp_coord(input longint v, inout bit clip);
        if (v > COORD_MAX) begin
            clip = 1'b1;
            return COORD_MAX;
        end
        if (v < COORD_MIN) begin
            clip = 1'b1;
            return COORD_MIN;
        end
        return v;
    endfunction

    // advance heading/position by one command, return the result it causes
    function automatic result_t integrate_command(input logic [OP_W-1:0] op,
                                                  input logic [POS_W-1:0] lx,
                                                  input logic [POS_W-1:0] ly);
        int      step;
        longint  vx;
        longint  vy;
        bit      clip;
        result_t r;
        clip = 1'b0;
        step = turn_cfg;
        // oversized turn steps fold back into one revolution
        if (step >= TURN_UNITS) begin
            step -= TURN_UNITS;
        end
        case (op)
            OP_ROT_R: begin
                hdg_st += step;
                if (hdg_st >= TURN_UNITS) begin
                    hdg_st -= TURN_UNITS;
                end
            end
            OP_ROT_L: begin
                if (hdg_st >= step) begin
                    hdg_st -= step;
                end else begin
                    hdg_st = hdg_st + TURN_UNITS - step;
                end
            end
            OP_FWD, OP_BWD: begin
                heading_velocity(hdg_st, vx, vy);
                if (op == OP_FWD) begin
                    px_st = clamp_coord(px_st + vx, clip);
                    py_st = clamp_coord(py_st + vy, clip);
                end else begin
                    px_st = clamp_coord(px_st - vx, clip);
                    py_st = clamp_coord(py_st - vy, clip);
                end
            end
            OP_LOAD: begin
                px_st = longint'($signed(lx));
                py_st = longint'($signed(ly));
            end
            default: begin
                // hold, and the two unused codes behave the same
            end
        endcase
        // velocity always follows the heading after the step
        heading_velocity(hdg_st, vx, vy);
        r.pos_x     = px_st[POS_W-1:0];
        r.pos_y     = py_st[POS_W-1:0];
        r.heading   = hdg_st[HDG_W-1:0];
        r.vel_x     = vx[VEL_W-1:0];
        r.vel_y     = vy[VEL_W-1:0];
        r.saturated = clip;
        if (clip) begin
            n_clipped++;
        end
        return r;
    endfunction

    // track register writes, predict on command beats, compare result beats
    always @(posedge aclk) begin
        result_t seen;
        result_t want;
        if (!aresetn) begin
            turn_cfg  = int'(TURN_STEP_RST);
            speed_cfg = int'(MOVE_SPEED_RST);
            hdg_st    = 0;
            px_st     = 0;
            py_st     = 0;
            expected_beats.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_wr_index == CFG_TURN_STEP) begin
                    turn_cfg = int'(cfg_wr_data[HDG_W-1:0]);
                end else if (cfg_wr_index == CFG_MOVE_SPEED) begin
                    speed_cfg = int'(cfg_wr_data[SPEED_W-1:0]);
                end
            end
            if (s_tvalid && s_tready) begin
                expected_beats.push_back(integrate_command(s_tdata[OP_W-1:0],
                                                           s_tdata[OP_W +: POS_W],
                                                           s_tdata[OP_W+POS_W +: POS_W]));
            end
            if (m_tvalid && m_tready) begin
                seen.pos_x     = m_tdata[0 +: POS_W];
                seen.pos_y     = m_tdata[POS_W +: POS_W];
                seen.heading   = m_tdata[2*POS_W +: HDG_W];
                seen.vel_x     = m_tdata[2*POS_W+HDG_W +: VEL_W];
                seen.vel_y     = m_tdata[2*POS_W+HDG_W+VEL_W +: VEL_W];
                seen.saturated = m_tdata[2*POS_W+HDG_W+2*VEL_W];
                if (expected_beats.size() == 0) begin
                    flag_error($sformatf("result beat with no command pending, data 0x%0h",
                                         m_tdata));
                end else begin
                    want = expected_beats.pop_front();
                    check_field("pos_x", seen.pos_x, want.pos_x);
                    check_field("pos_y", seen.pos_y, want.pos_y);
                    check_field("heading", seen.heading, want.heading);
                    check_field("vel_x", seen.vel_x, want.vel_x);
                    check_field("vel_y", seen.vel_y, want.vel_y);
                    check_field("saturated", seen.saturated, want.saturated);
                    n_checked++;
                end
            end
        end
        n_pending = expected_beats.size();
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for heading_position_integrator_unit. A directed
// opening covers every opcode, wrap-around, position clipping and register
// extremes; then random command phases run under varied register settings
// with random gaps on the command side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;
    import hpi_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
    localparam logic [POS_W-1:0] COORD_TOP = 24'h7FFFFF;
    localparam logic [POS_W-1:0] COORD_BOT = 24'h800000;
    localparam int N_PHASES     = 9;
    localparam int PHASE_ITEMS  = 100;
    localparam int SETTLE_TICKS = 10;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;

    int  error_count;
    int  pending_count;
    int  beats_checked;
    int  clipped_moves;

    // idling control: a calm side never idles
    bit  src_calm = 1'b1;
    bit  snk_calm = 1'b1;

    int  n_rot;
    int  n_move;
    int  n_load;
    int  n_hold;
    int  n_reg_writes;

    heading_position_integrator_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    hpi_scoreboard u_scoreboard (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .error_count   (error_count),
        .pending_count (pending_count),
        .beats_checked (beats_checked),
        .clipped_moves (clipped_moves)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("Timeout with %0d results outstanding", pending_count);
        $display("Test completed with failures");
        $finish;
    end

    // mostly no gap, some short, a few long
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end else if (r < 99) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // result side: random stalls
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!snk_calm) begin
                    stall_left = draw_gap();
                end
            end
        end
    end

    // drive one command beat and wait until it is taken
    task automatic send_command(input logic [OP_W-1:0] op, input logic [POS_W-1:0] lx,
                                input logic [POS_W-1:0] ly);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({ly, lx, op});
        do begin
            @(posedge aclk);
        end while (!s_tready);
        case (op)
            OP_ROT_R, OP_ROT_L: n_rot++;
            OP_FWD, OP_BWD:     n_move++;
            OP_LOAD:            n_load++;
            default:            n_hold++;
        endcase
    endtask

    task automatic pause_source(input int n);
        if (n > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        drain_results();
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
        n_reg_writes++;
    endtask

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return OP_ROT_R;
        if (r < 30) return OP_ROT_L;
        if (r < 55) return OP_FWD;
        if (r < 75) return OP_BWD;
        if (r < 85) return OP_LOAD;
        if (r < 95) return OP_HOLD;
        if (r < 98) return OP_SPARE_6;
        return OP_SPARE_7;
    endfunction

    // load targets biased toward the range ends so moves clip
    function automatic logic [POS_W-1:0] pick_coord();
        case ($urandom_range(0, 3))
            0:       return POS_W'($urandom);
            1:       return COORD_TOP - POS_W'($urandom_range(0, 90000));
            2:       return COORD_BOT + POS_W'($urandom_range(0, 90000));
            default: return POS_W'($urandom_range(0, 2000) - 1000);
        endcase
    endfunction

    // register values for each random phase, extremes in phases 1 to 4
    task automatic setup_phase(input int ph);
        case (ph)
            1: begin
                write_reg(CFG_TURN_STEP, 16'd0);
                write_reg(CFG_MOVE_SPEED, 16'hFFFF);
            end
            2: begin
                write_reg(CFG_TURN_STEP, 16'd23039);
                write_reg(CFG_MOVE_SPEED, 16'd1);
            end
            3: begin
                write_reg(CFG_TURN_STEP, 16'd23040);
                write_reg(CFG_MOVE_SPEED, 16'd0);
            end
            4: begin
                write_reg(CFG_TURN_STEP, 16'hFFFF);
                write_reg(CFG_MOVE_SPEED, 16'hFFFF);
            end
            5: begin
                write_reg(CFG_TURN_STEP, 16'd5760);
                write_reg(CFG_MOVE_SPEED, CFG_W'($urandom_range(0, 65535)));
            end
            default: begin
                write_reg(CFG_TURN_STEP, CFG_W'($urandom_range(0, 65535)));
                write_reg(CFG_MOVE_SPEED, CFG_W'($urandom_range(0, 65535)));
            end
        endcase
    endtask

    initial begin
        logic [OP_W-1:0] op;
        logic [POS_W-1:0] lx;
        logic [POS_W-1:0] ly;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: every opcode, heading wrap, clipping, register extremes
        send_command(OP_HOLD, '0, '0);
        send_command(OP_SPARE_6, '1, '1);
        send_command(OP_SPARE_7, '0, '1);
        send_command(OP_FWD, '1, '0);
        send_command(OP_BWD, '0, '0);
        send_command(OP_ROT_R, '0, '0);
        send_command(OP_ROT_L, '0, '0);
        send_command(OP_ROT_L, '0, '0);
        send_command(OP_LOAD, COORD_TOP, COORD_BOT);
        send_command(OP_FWD, '0, '0);
        send_command(OP_LOAD, COORD_BOT, COORD_TOP);
        send_command(OP_BWD, '0, '0);
        send_command(OP_LOAD, '0, '0);
        send_command(OP_HOLD, '1, '1);
        // oversized turn step, with the unused top data bit set; full speed
        write_reg(CFG_TURN_STEP, 16'hFFFF);
        write_reg(CFG_MOVE_SPEED, 16'hFFFF);
        send_command(OP_ROT_R, '0, '0);
        send_command(OP_ROT_R, '0, '0);
        send_command(OP_ROT_L, '0, '0);
        send_command(OP_FWD, '0, '0);
        send_command(OP_BWD, '0, '0);
        send_command(OP_LOAD, COORD_TOP, COORD_TOP);
        send_command(OP_FWD, '0, '0);
        // quarter turns, each followed by a move
        write_reg(CFG_TURN_STEP, 16'd5760);
        send_command(OP_ROT_R, '0, '0);
        send_command(OP_FWD, '0, '0);
        send_command(OP_ROT_R, '0, '0);
        send_command(OP_FWD, '0, '0);

        // random phases under changing register settings
        for (int ph = 0; ph < N_PHASES; ph++) begin
            setup_phase(ph);
            src_calm = (ph == 0) || ($urandom_range(0, 3) == 0);
            snk_calm = (ph == 0) || ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                op = pick_op();
                if (op == OP_LOAD) begin
                    lx = pick_coord();
                    ly = pick_coord();
                end else begin
                    lx = POS_W'($urandom);
                    ly = POS_W'($urandom);
                end
                send_command(op, lx, ly);
                // hold off until the pipeline is empty now and then
                if (i == PHASE_ITEMS / 2) begin
                    drain_results();
                end else if (!src_calm) begin
                    pause_source(draw_gap());
                end
                if (ph != 0 && $urandom_range(0, 39) == 0) begin
                    src_calm = ~src_calm;
                end
                if (ph != 0 && $urandom_range(0, 39) == 0) begin
                    snk_calm = ~snk_calm;
                end
            end
        end

        drain_results();

        $display("Covered %0d commands: %0d rotates, %0d moves, %0d loads, %0d holds/unused",
                 n_rot + n_move + n_load + n_hold, n_rot, n_move, n_load, n_hold);
        $display("%0d result beats compared, %0d clipped moves, %0d register writes",
                 beats_checked, clipped_moves, n_reg_writes);
        if (error_count == 0 && pending_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
